/* hw/rtl/itp_pkg.sv */
package itp_pkg;

	// most words one input symbol can produce
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// character codes
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NL      = 8'h0a;
	localparam logic [7:0] CH_OPEN    = 8'h28;
	localparam logic [7:0] CH_CLOSE   = 8'h29;
	localparam logic [7:0] CH_MUL     = 8'h2a;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_DIV     = 8'h2f;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_POW     = 8'h5e;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;

	// error codes on the result word
	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNMATCHED = 2'd2;

	// stack entry codes
	typedef enum logic [2:0] {
		OP_OPEN  = 3'd0,
		OP_PLUS  = 3'd1,
		OP_MINUS = 3'd2,
		OP_MUL   = 3'd3,
		OP_DIV   = 3'd4,
		OP_POW   = 3'd5
	} op_code_t;

	// input symbol classes
	typedef enum logic [2:0] {
		CLS_OTHER = 3'd0,
		CLS_ALNUM = 3'd1,
		CLS_OPEN  = 3'd2,
		CLS_CLOSE = 3'd3,
		CLS_END   = 3'd4,
		CLS_OP    = 3'd5
	} sym_class_t;

	// source of a generated result word
	typedef enum logic [2:0] {
		SRC_SYM = 3'd0,
		SRC_TOP = 3'd1,
		SRC_NL  = 3'd2,
		SRC_OVF = 3'd3,
		SRC_UNM = 3'd4
	} gen_src_t;

	// commands from controller to datapath
	typedef struct packed {
		logic     sel_in;
		logic     load_sym;
		logic     gen;
		gen_src_t src;
		logic     push;
		logic     pop;
		logic     restore;
		logic     reload;
		logic     flush;
	} itp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		sym_class_t cls;
		logic       pop_cond;
		logic       full;
		logic       le1;
		logic       stall;
		logic       pend_valid;
		logic       out_free;
	} itp_status_t;

	function automatic sym_class_t sym_class(input logic [7:0] s);
		sym_class_t c;
		c = CLS_OTHER;
		if ((s >= CH_UPPER_A && s <= CH_UPPER_Z) || (s >= CH_LOWER_A && s <= CH_LOWER_Z) ||
		    (s >= CH_ZERO && s <= CH_NINE)) begin
			c = CLS_ALNUM;
		end else if (s == CH_OPEN) begin
			c = CLS_OPEN;
		end else if (s == CH_CLOSE) begin
			c = CLS_CLOSE;
		end else if (s == CH_NUL) begin
			c = CLS_END;
		end else if (s == CH_PLUS || s == CH_MINUS || s == CH_MUL || s == CH_DIV ||
		             s == CH_POW) begin
			c = CLS_OP;
		end
		return c;
	endfunction

	function automatic op_code_t sym_op(input logic [7:0] s);
		op_code_t o;
		case (s)
			CH_PLUS:  o = OP_PLUS;
			CH_MINUS: o = OP_MINUS;
			CH_MUL:   o = OP_MUL;
			CH_DIV:   o = OP_DIV;
			CH_POW:   o = OP_POW;
			default:  o = OP_OPEN;
		endcase
		return o;
	endfunction

	function automatic logic [1:0] op_prec(input op_code_t o);
		logic [1:0] p;
		case (o)
			OP_PLUS, OP_MINUS: p = 2'd1;
			OP_MUL, OP_DIV:    p = 2'd2;
			OP_POW:            p = 2'd3;
			default:           p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] op_char(input op_code_t o);
		logic [7:0] ch;
		case (o)
			OP_OPEN:  ch = CH_OPEN;
			OP_PLUS:  ch = CH_PLUS;
			OP_MINUS: ch = CH_MINUS;
			OP_MUL:   ch = CH_MUL;
			OP_DIV:   ch = CH_DIV;
			OP_POW:   ch = CH_POW;
			default:  ch = CH_NUL;
		endcase
		return ch;
	endfunction

endpackage

/* hw/rtl/infix_to_postfix_converter_core.sv */
// a letter or digit that is taken goes through the held-word register, then the output register
// throughput: an ignored symbol is taken every cycle; any other symbol is taken only once
// the work for the one before is done, and each operator popped adds to that work
// each pop waits on the registered read port of the stack memory; output stalls add
// reset: stack pointer returns to one with the sentinel held in a register, no clearing pass
module infix_to_postfix_converter_core #(
	parameter int STACK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last_of_run,
	output logic [1:0] error_code
);

	import itp_pkg::*;

	itp_cmd_t    cmd;
	itp_status_t status;

	// sequencer
	itp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	// stack, result holding and output register
	itp_dpath #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.symbol     (symbol),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.last_of_run(last_of_run),
		.error_code (error_code)
	);

endmodule

/* hw/rtl/itp_ram.sv */
module itp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/itp_ctrl.sv */
module itp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  itp_pkg::itp_status_t status,
	output itp_pkg::itp_cmd_t    cmd
);

	import itp_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_POP   = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_LOAD  = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.sel_in = 1'b1;
				if (in_valid) begin
					cmd.load_sym = 1'b1;
					case (status.cls)
						CLS_ALNUM: begin
							cmd.gen = 1'b1;
							cmd.src = SRC_SYM;
							state_d = ST_FLUSH;
						end
						CLS_OPEN: begin
							if (status.full) begin
								cmd.gen = 1'b1;
								cmd.src = SRC_OVF;
							end else begin
								cmd.push = 1'b1;
							end
							state_d = ST_FLUSH;
						end
						CLS_CLOSE, CLS_END, CLS_OP: begin
							state_d = ST_POP;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_POP: begin
				if (status.pop_cond) begin
					// emit the top operator and fetch the one below
					if (!status.stall) begin
						cmd.gen = 1'b1;
						cmd.src = SRC_TOP;
						cmd.pop = 1'b1;
						state_d = ST_WAIT;
					end
				end else begin
					case (status.cls)
						CLS_CLOSE: begin
							if (status.le1) begin
								if (!status.stall) begin
									cmd.gen = 1'b1;
									cmd.src = SRC_UNM;
									state_d = ST_FLUSH;
								end
							end else begin
								cmd.pop = 1'b1;
								state_d = ST_LOAD;
							end
						end
						CLS_END: begin
							if (!status.stall) begin
								cmd.gen     = 1'b1;
								cmd.src     = SRC_NL;
								cmd.restore = 1'b1;
								state_d     = ST_FLUSH;
							end
						end
						CLS_OP: begin
							if (status.full) begin
								if (!status.stall) begin
									cmd.gen = 1'b1;
									cmd.src = SRC_OVF;
									state_d = ST_FLUSH;
								end
							end else begin
								cmd.push = 1'b1;
								state_d  = ST_FLUSH;
							end
						end
						default: begin
							state_d = ST_FLUSH;
						end
					endcase
				end
			end
			ST_WAIT: begin
				cmd.reload = 1'b1;
				state_d    = ST_POP;
			end
			ST_LOAD: begin
				cmd.reload = 1'b1;
				state_d    = ST_FLUSH;
			end
			ST_FLUSH: begin
				// hand the held word over as the last of the run
				cmd.flush = 1'b1;
				if (!status.pend_valid || status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/itp_dpath.sv */
module itp_dpath #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           symbol,
	input  itp_pkg::itp_cmd_t    cmd,
	output itp_pkg::itp_status_t status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_char,
	output logic                 last_of_run,
	output logic [1:0]           error_code
);

	import itp_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);

	logic [SPW-1:0]   sp_q;
	op_code_t         top_q;
	logic [7:0]       sym_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_valid_q;
	logic [7:0]       pend_char_q;
	logic [1:0]       pend_err_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_last_q;
	logic [1:0]       out_err_q;

	logic [7:0]       cur_sym;
	sym_class_t       cls;
	op_code_t         cur_op;
	logic [CNT_W-1:0] cnt_eff;
	logic             room;
	logic             out_free;
	logic             gen_take;
	logic             flush_take;
	logic [7:0]       gen_char;
	logic [1:0]       gen_err;
	logic [SPW-1:0]   sp_m2;
	logic [2:0]       rdata;

	// symbol under work and its class
	assign cur_sym = cmd.sel_in ? symbol : sym_q;
	assign cls     = sym_class(cur_sym);
	assign cur_op  = sym_op(cur_sym);

	// result count within the current symbol
	assign cnt_eff  = cmd.load_sym ? '0 : cnt_q;
	assign room     = (cnt_eff != CNT_W'(MAX_RESULTS));
	assign out_free = !out_valid_q || out_ready;

	assign gen_take   = cmd.gen && room;
	assign flush_take = cmd.flush && pend_valid_q && out_free;

	// generated word
	always_comb begin
		gen_char = CH_NUL;
		gen_err  = ERR_OK;
		case (cmd.src)
			SRC_SYM: gen_char = cur_sym;
			SRC_TOP: gen_char = op_char(top_q);
			SRC_NL:  gen_char = CH_NL;
			SRC_OVF: gen_err  = ERR_OVERFLOW;
			SRC_UNM: gen_err  = ERR_UNMATCHED;
			default: gen_char = CH_NUL;
		endcase
	end

	// status to the controller
	always_comb begin
		status.cls = cls;
		case (cls)
			CLS_CLOSE, CLS_END: status.pop_cond = (top_q != OP_OPEN);
			CLS_OP:             status.pop_cond = (op_prec(cur_op) <= op_prec(top_q));
			default:            status.pop_cond = 1'b0;
		endcase
		status.full       = (sp_q == SPW'(STACK_DEPTH));
		status.le1        = (sp_q <= SPW'(1));
		status.stall      = pend_valid_q && !out_free && room;
		status.pend_valid = pend_valid_q;
		status.out_free   = out_free;
	end

	// operator stack storage, top kept in a register
	assign sp_m2 = sp_q - SPW'(2);

	itp_ram #(
		.WIDTH(3),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(sp_q[AW-1:0]),
		.wdata(cur_op),
		.raddr(sp_m2[AW-1:0]),
		.rdata(rdata)
	);

	// stack pointer and top of stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= SPW'(1);
			top_q <= OP_OPEN;
		end else begin
			if (cmd.push) begin
				sp_q  <= sp_q + SPW'(1);
				top_q <= cur_op;
			end else if (cmd.pop) begin
				sp_q <= sp_q - SPW'(1);
			end else if (cmd.restore) begin
				sp_q  <= SPW'(1);
				top_q <= OP_OPEN;
			end else if (cmd.reload) begin
				// the sentinel is never read back from the array
				top_q <= (sp_q == SPW'(1)) ? OP_OPEN : op_code_t'(rdata);
			end
		end
	end

	// latched symbol
	always_ff @(posedge clk) begin
		if (cmd.load_sym) begin
			sym_q <= symbol;
		end
	end

	// held word, one behind so the last of the run can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (gen_take) begin
				pend_valid_q <= 1'b1;
				cnt_q        <= cnt_eff + CNT_W'(1);
			end else begin
				if (flush_take) begin
					pend_valid_q <= 1'b0;
				end
				if (cmd.load_sym) begin
					cnt_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen_take) begin
			pend_char_q <= gen_char;
			pend_err_q  <= gen_err;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((gen_take && pend_valid_q) || flush_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((gen_take && pend_valid_q) || flush_take) begin
			out_char_q <= pend_char_q;
			out_err_q  <= pend_err_q;
			out_last_q <= flush_take;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = out_last_q;
	assign error_code  = out_err_q;

endmodule

/* hw/rtl/itp_checker.sv */
module itp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] symbol,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       last_of_run,
	input logic [1:0] error_code
);

	import itp_pkg::*;

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) &&
		$stable(error_code) && $stable(last_of_run))
		else $error("stalled result word changed");

	// only defined error codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= ERR_UNMATCHED)
		else $error("undefined error code");

	// error words carry no character
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_OK |-> out_char == CH_NUL)
		else $error("error word with a character");

	// errors and newlines close a run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code != ERR_OK || out_char == CH_NL) |-> last_of_run)
		else $error("error or newline not last of run");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (.*);

/* tb/postfix_checker.sv */
module postfix_checker #(
	parameter int STACK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] symbol,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_char,
	input  logic       last_of_run,
	input  logic [1:0] error_code,
	output int         mismatches,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import itp_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic [1:0] err;
	} postfix_word_t;

	// words still owed by the block, oldest first
	postfix_word_t postfix_q[$];
	// words caused by the symbol being converted
	postfix_word_t run_q[$];

	// shadow operator stack
	op_code_t op_stack[STACK_DEPTH];
	int       depth_used;
	int       err_count;

	function automatic int rank(input op_code_t o);
		case (o)
			OP_POW:            return 3;
			OP_MUL, OP_DIV:    return 2;
			OP_PLUS, OP_MINUS: return 1;
			default:           return 0;
		endcase
	endfunction

	function automatic logic [7:0] glyph(input op_code_t o);
		case (o)
			OP_PLUS:  return CH_PLUS;
			OP_MINUS: return CH_MINUS;
			OP_MUL:   return CH_MUL;
			OP_DIV:   return CH_DIV;
			OP_POW:   return CH_POW;
			default:  return CH_OPEN;
		endcase
	endfunction

	// one symbol never yields more than MAX_RESULTS words
	function void put_word(input logic [7:0] ch, input logic [1:0] err);
		if (run_q.size() < MAX_RESULTS) begin
			run_q.push_back({ch, 1'b0, err});
		end
	endfunction

	function void reseat_sentinel();
		op_stack[0] = OP_OPEN;
		depth_used = 1;
	endfunction

	// pop down to the nearest open paren, leaving it; 0 on underflow
	function bit unwind_to_open();
		while (1) begin
			if (depth_used == 0 || depth_used > STACK_DEPTH) begin
				put_word(CH_NUL, ERR_UNMATCHED);
				reseat_sentinel();
				return 1'b0;
			end
			if (op_stack[depth_used - 1] == OP_OPEN) begin
				return 1'b1;
			end
			put_word(glyph(op_stack[depth_used - 1]), ERR_OK);
			depth_used--;
		end
		return 1'b0;
	endfunction

	function void convert_symbol(input logic [7:0] s);
		op_code_t      code;
		bit            is_op;
		bit            ok;
		bit            scanning;
		postfix_word_t w;
		run_q.delete();
		is_op = 1'b1;
		case (s)
			CH_PLUS:  code = OP_PLUS;
			CH_MINUS: code = OP_MINUS;
			CH_MUL:   code = OP_MUL;
			CH_DIV:   code = OP_DIV;
			CH_POW:   code = OP_POW;
			default: begin
				code = OP_OPEN;
				is_op = 1'b0;
			end
		endcase

		if ((s >= CH_UPPER_A && s <= CH_UPPER_Z) || (s >= CH_LOWER_A && s <= CH_LOWER_Z) ||
		    (s >= CH_ZERO && s <= CH_NINE)) begin
			// operands go straight out
			put_word(s, ERR_OK);
		end else if (s == CH_OPEN) begin
			if (depth_used >= STACK_DEPTH) begin
				put_word(CH_NUL, ERR_OVERFLOW);
			end else begin
				op_stack[depth_used] = OP_OPEN;
				depth_used++;
			end
		end else if (s == CH_CLOSE) begin
			// close that reaches the sentinel is unmatched
			if (unwind_to_open()) begin
				if (depth_used <= 1) begin
					put_word(CH_NUL, ERR_UNMATCHED);
				end else begin
					depth_used--;
				end
			end
		end else if (s == CH_NUL) begin
			// end of expression: flush to open, newline, drop the rest
			void'(unwind_to_open());
			put_word(CH_NL, ERR_OK);
			reseat_sentinel();
		end else if (is_op) begin
			// pop while incoming precedence does not beat the top
			ok = 1'b1;
			scanning = 1'b1;
			while (scanning) begin
				if (depth_used == 0 || depth_used > STACK_DEPTH) begin
					put_word(CH_NUL, ERR_UNMATCHED);
					reseat_sentinel();
					ok = 1'b0;
					scanning = 1'b0;
				end else if (rank(code) > rank(op_stack[depth_used - 1])) begin
					scanning = 1'b0;
				end else begin
					put_word(glyph(op_stack[depth_used - 1]), ERR_OK);
					depth_used--;
				end
			end
			if (ok) begin
				if (depth_used >= STACK_DEPTH) begin
					put_word(CH_NUL, ERR_OVERFLOW);
				end else begin
					op_stack[depth_used] = code;
					depth_used++;
				end
			end
		end

		// mark the last word of the run
		for (int i = 0; i < run_q.size(); i++) begin
			w = run_q[i];
			w.last = (i == run_q.size() - 1);
			postfix_q.push_back(w);
		end
	endfunction

	function void check_word();
		postfix_word_t w;
		if (postfix_q.size() == 0) begin
			$display("%0t unexpected word: out_char %h last %b error %0d",
			         $time, out_char, last_of_run, error_code);
			err_count++;
		end else begin
			w = postfix_q.pop_front();
			if (out_char !== w.ch) begin
				$display("%0t out_char expected %h got %h", $time, w.ch, out_char);
				err_count++;
			end
			if (last_of_run !== w.last) begin
				$display("%0t last_of_run expected %b got %b", $time, w.last, last_of_run);
				err_count++;
			end
			if (error_code !== w.err) begin
				$display("%0t error_code expected %0d got %0d", $time, w.err, error_code);
				err_count++;
			end
		end
	endfunction

	// output words are matched before the new symbol is converted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STACK_DEPTH; i++) begin
				op_stack[i] = OP_OPEN;
			end
			reseat_sentinel();
			postfix_q.delete();
			err_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				check_word();
			end
			if (in_valid && in_ready) begin
				convert_symbol(symbol);
			end
			mismatches <= err_count;
			pending <= postfix_q.size();
		end
	end

endmodule

/* tb/infix_to_postfix_converter_core_test.sv */
module infix_to_postfix_converter_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import itp_pkg::*;

	localparam int ITEM_GOAL = 430;
	localparam int LIMIT     = 600000;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] symbol    = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       last_of_run;
	logic [1:0] error_code;

	int mismatches;
	int pending;

	int idle_pct  = 0;
	int stall_pct = 0;
	bit tx_calm   = 1'b0;
	bit rx_calm   = 1'b0;
	int cycles    = 0;
	int counted   = 0;
	int phase     = 0;

	// symbols of the next round, in send order
	logic [7:0] expr_q[$];

	infix_to_postfix_converter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.last_of_run(last_of_run),
		.error_code (error_code)
	);

	postfix_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.last_of_run(last_of_run),
		.error_code (error_code),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver back-pressure with occasional calm stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_calm <= 1'b0;
		end else begin
			if ($urandom_range(199) == 0) begin
				rx_calm <= !rx_calm;
			end
			out_ready <= rx_calm || ($urandom_range(99) >= stall_pct);
		end
	end

	// symbols the block acts on; everything else is ignored
	function automatic bit is_active(input logic [7:0] s);
		return (s >= CH_UPPER_A && s <= CH_UPPER_Z) || (s >= CH_LOWER_A && s <= CH_LOWER_Z) ||
		       (s >= CH_ZERO && s <= CH_NINE) || s == CH_OPEN || s == CH_CLOSE ||
		       s == CH_NUL || s == CH_PLUS || s == CH_MINUS || s == CH_MUL ||
		       s == CH_DIV || s == CH_POW;
	endfunction

	function automatic logic [7:0] pick_operand();
		case ($urandom_range(2))
			0:       return CH_UPPER_A + 8'($urandom_range(25));
			1:       return CH_LOWER_A + 8'($urandom_range(25));
			default: return CH_ZERO + 8'($urandom_range(9));
		endcase
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(4))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_MUL;
			3:       return CH_DIV;
			default: return CH_POW;
		endcase
	endfunction

	function automatic logic [7:0] noise_symbol();
		logic [7:0] s;
		do begin
			s = 8'($urandom_range(255));
		end while (is_active(s));
		return s;
	endfunction

	// well-formed expression with random content and stray noise
	function automatic void build_expr(input int nest);
		int terms;
		terms = $urandom_range(1, 4);
		for (int i = 0; i < terms; i++) begin
			if (i > 0) begin
				expr_q.push_back(pick_operator());
			end
			if ($urandom_range(11) == 0) begin
				expr_q.push_back(noise_symbol());
			end
			if (nest < 3 && $urandom_range(3) == 0) begin
				expr_q.push_back(CH_OPEN);
				build_expr(nest + 1);
				expr_q.push_back(CH_CLOSE);
			end else begin
				expr_q.push_back(pick_operand());
			end
		end
	endfunction

	function automatic void build_round();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 65) begin
			build_expr(0);
			expr_q.push_back(CH_NUL);
		end else if (kind < 78) begin
			// broken sequence of live symbols
			n = $urandom_range(3, 10);
			repeat (n) begin
				case ($urandom_range(3))
					0:       expr_q.push_back(pick_operand());
					1:       expr_q.push_back(pick_operator());
					2:       expr_q.push_back(CH_OPEN);
					default: expr_q.push_back(CH_CLOSE);
				endcase
			end
			if ($urandom_range(1) == 1) begin
				expr_q.push_back(CH_NUL);
			end
		end else if (kind < 88) begin
			// deep nesting up to and past a full stack
			n = $urandom_range(28, 34);
			repeat (n) expr_q.push_back(CH_OPEN);
			expr_q.push_back(pick_operator());
			expr_q.push_back(pick_operand());
			repeat ($urandom_range(0, n + 2)) expr_q.push_back(CH_CLOSE);
			expr_q.push_back(CH_NUL);
		end else if (kind < 95) begin
			// raw bytes of any value
			repeat ($urandom_range(2, 8)) expr_q.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 3)) expr_q.push_back(CH_CLOSE);
			expr_q.push_back(CH_NUL);
		end
	endfunction

	// offer one word and hold it until taken
	task automatic send_word(input logic [7:0] s);
		while (!tx_calm && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= s;
		do begin
			@(posedge clk);
		end while (!in_ready);
		if (is_active(s)) begin
			counted++;
		end
	endtask

	task automatic send_text(input string t);
		for (int i = 0; i < t.len(); i++) begin
			send_word(t[i]);
		end
	endtask

	task automatic send_round();
		foreach (expr_q[i]) begin
			send_word(expr_q[i]);
		end
		expr_q.delete();
	endtask

	// hold off until every owed word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic enter_phase(input int p);
		drain_results();
		case (p)
			1: begin
				idle_pct = 82;
				stall_pct <= 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct <= 82;
			end
			default: begin
				idle_pct = 36;
				stall_pct <= 36;
			end
		endcase
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// left-assoc power
		send_text("a^b^c");
		send_word(CH_NUL);
		// all operators but power, parens, operand extremes
		send_text("(A+z)*0/9-Z");
		send_word(CH_NUL);
		// ignored bytes
		send_word(8'h20);
		send_word(8'hff);
		send_word(8'h80);
		// unmatched close
		send_word(CH_CLOSE);
		send_word(CH_NUL);
		// unclosed open at end
		send_text("((x");
		send_word(8'h7f);
		send_word(CH_NUL);

		// random rounds through the idling phases
		while (counted < ITEM_GOAL) begin
			if (phase < 3 && counted * 4 / ITEM_GOAL > phase) begin
				phase++;
				enter_phase(phase);
			end
			tx_calm = ($urandom_range(5) == 0);
			build_round();
			send_round();
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
